@@ design/fbfl_pkg.sv @@
`timescale 1ns / 1ps

package fbfl_pkg;

    // Default sizing of the pool
    localparam int PAGE_BYTES_DEF = 4096;
    localparam int MAX_BLOCKS_DEF = 512;

    // Fixed field widths
    localparam int OFF_W   = 12;
    localparam int FB_W    = 10;
    localparam int LOG2_W  = 4;

    // Block size code after reset
    localparam logic [LOG2_W-1:0] BLK_LOG2_RST = LOG2_W'(5);

    // Request codes
    localparam logic REQ_ALLOC = 1'b0;
    localparam logic REQ_FREE  = 1'b1;

    // Result status codes
    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    // Request beat
    typedef struct packed {
        logic             req_type;
        logic [OFF_W-1:0] free_offset;
    } req_t;

    // Result beat
    typedef struct packed {
        status_t          status;
        logic [OFF_W-1:0] block_offset;
        logic [FB_W-1:0]  free_blocks;
    } resp_t;

endpackage

@@ design/fbfl_ram.sv @@
`timescale 1ns / 1ps

module fbfl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // One write port, one registered read port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ design/fixed_block_free_list_allocator_unit.sv @@
`timescale 1ns / 1ps

// Fixed-size block pool over one page, LIFO free list.
// s_ channel: one request per beat (allocate, or free the block at free_offset).
// m_ channel: exactly one result beat per request (status, block offset, free count).
// cfg channel: writes block_size_log2; always ready. Only write while the block
//   is idle. A write rebuilds the list and restarts the link table init pass.
// Result: shows on m_valid, registered, the cycle after its request beat is taken.
// Rate: one request per cycle while s_ready is high. Head and its next link are
//   held in flops; the link of a newly popped head is fetched from the link RAM
//   in the same cycle, so back-to-back allocates never wait on the RAM read.
// Reset (aresetn low, synchronous) and every config write start an init pass
//   that writes entry i of the link RAM with i+1 for all MAX_BLOCKS entries;
//   s_ready stays low for its duration.
// Stall: one result register; while it holds an untaken beat and m_ready is
//   low, s_ready is low. With m_ready high, s_ready follows in the same cycle.
module fixed_block_free_list_allocator_unit
    import fbfl_pkg::*;
#(
    parameter int PAGE_BYTES = PAGE_BYTES_DEF,
    parameter int MAX_BLOCKS = MAX_BLOCKS_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    // request channel
    input  logic              s_valid,
    output logic              s_ready,
    input  req_t              s_data,
    // result channel
    output logic              m_valid,
    input  logic              m_ready,
    output resp_t             m_data,
    // config channel
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [LOG2_W-1:0] cfg_data
);

    localparam int IDX_W = $clog2(MAX_BLOCKS);
    localparam int CNT_W = $clog2(MAX_BLOCKS + 1);
    localparam int SH_W  = CNT_W + 15;

    // Number of blocks for a given block size code
    function automatic logic [CNT_W-1:0] blk_count(input logic [LOG2_W-1:0] lg);
        logic [31:0] pg;
        pg = 32'(PAGE_BYTES) >> lg;
        if (pg > 32'(MAX_BLOCKS)) begin
            pg = 32'(MAX_BLOCKS);
        end
        if (pg == 32'd0) begin
            pg = 32'd1;
        end
        return CNT_W'(pg);
    endfunction

    logic [LOG2_W-1:0] shift_reg;
    logic [CNT_W-1:0]  blk_cnt_reg;
    logic [CNT_W-1:0]  head_reg,  head_next;
    logic [CNT_W-1:0]  link_reg,  link_next;
    logic              sel_reg,   sel_next;
    logic [CNT_W-1:0]  total_reg, total_next;
    logic              clr_busy_reg;
    logic [IDX_W-1:0]  clr_addr_reg;
    logic              m_valid_reg;
    resp_t             m_data_reg;
    resp_t             resp;

    logic              cfg_fire;
    logic              in_fire;
    logic [CNT_W-1:0]  cur_link;
    logic [OFF_W-1:0]  free_idx_raw;
    logic [IDX_W-1:0]  free_idx;
    logic [SH_W-1:0]   head_wide;
    logic              head_in_range;

    logic              ram_we;
    logic [IDX_W-1:0]  ram_waddr;
    logic [CNT_W-1:0]  ram_wdata;
    logic [IDX_W-1:0]  ram_raddr;
    logic [CNT_W-1:0]  ram_rdata;

    // Link table
    fbfl_ram #(
        .WIDTH (CNT_W),
        .DEPTH (MAX_BLOCKS)
    ) u_link_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Handshakes
    assign cfg_ready = 1'b1;
    assign cfg_fire  = cfg_valid;
    assign s_ready   = !clr_busy_reg && (!m_valid_reg || m_ready);
    assign in_fire   = s_valid && s_ready;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;

    // Link of the current head: RAM data the cycle after a pop, else the flop
    assign cur_link = sel_reg ? ram_rdata : link_reg;

    // Block index of a free, clamped to the last block
    assign free_idx_raw = s_data.free_offset >> shift_reg;
    assign free_idx = (32'(free_idx_raw) >= 32'(blk_cnt_reg)) ?
                      IDX_W'(blk_cnt_reg - CNT_W'(1)) : IDX_W'(free_idx_raw);

    // Byte offset of the head block
    assign head_wide     = SH_W'(head_reg) << shift_reg;
    assign head_in_range = 32'(head_reg) < 32'(MAX_BLOCKS);

    // Request processing
    always_comb begin
        head_next  = head_reg;
        link_next  = cur_link;
        sel_next   = 1'b0;
        total_next = total_reg;
        ram_we     = 1'b0;
        ram_waddr  = free_idx;
        ram_wdata  = head_reg;
        ram_raddr  = IDX_W'(cur_link);

        resp.status       = ST_OK;
        resp.block_offset = '0;

        // init pass: entry i links to i+1
        if (clr_busy_reg) begin
            ram_we    = 1'b1;
            ram_waddr = clr_addr_reg;
            ram_wdata = CNT_W'(clr_addr_reg) + CNT_W'(1);
        end

        if (in_fire) begin
            case (s_data.req_type)
                REQ_ALLOC: begin
                    if (total_reg == '0) begin
                        resp.status = ST_EMPTY;
                    end else begin
                        resp.block_offset = head_wide[OFF_W-1:0];
                        total_next        = total_reg - CNT_W'(1);
                        // pop; fetch the new head's link right away
                        if (head_in_range) begin
                            head_next = cur_link;
                            sel_next  = 1'b1;
                        end
                    end
                end
                REQ_FREE: begin
                    if (total_reg >= blk_cnt_reg) begin
                        resp.status = ST_FULL;
                    end else begin
                        // push: freed block links to old head
                        ram_we     = 1'b1;
                        head_next  = CNT_W'(free_idx);
                        link_next  = head_reg;
                        total_next = total_reg + CNT_W'(1);
                    end
                end
                default: begin
                end
            endcase
        end

        resp.free_blocks = FB_W'(total_next);
    end

    // List state and init pass
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            shift_reg    <= BLK_LOG2_RST;
            blk_cnt_reg  <= blk_count(BLK_LOG2_RST);
            head_reg     <= '0;
            link_reg     <= CNT_W'(1);
            sel_reg      <= 1'b0;
            total_reg    <= blk_count(BLK_LOG2_RST);
            clr_busy_reg <= 1'b1;
            clr_addr_reg <= '0;
        end else if (cfg_fire) begin
            shift_reg    <= cfg_data;
            blk_cnt_reg  <= blk_count(cfg_data);
            head_reg     <= '0;
            link_reg     <= CNT_W'(1);
            sel_reg      <= 1'b0;
            total_reg    <= blk_count(cfg_data);
            clr_busy_reg <= 1'b1;
            clr_addr_reg <= '0;
        end else begin
            head_reg  <= head_next;
            link_reg  <= link_next;
            sel_reg   <= sel_next;
            total_reg <= total_next;
            if (clr_busy_reg) begin
                clr_addr_reg <= clr_addr_reg + IDX_W'(1);
                if (clr_addr_reg == IDX_W'(MAX_BLOCKS - 1)) begin
                    clr_busy_reg <= 1'b0;
                end
            end
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (in_fire) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_fire) begin
            m_data_reg <= resp;
        end
    end

endmodule

@@ design/fbfl_checker.sv @@
`timescale 1ns / 1ps

module fbfl_checker
    import fbfl_pkg::*;
(
    input logic  aclk,
    input logic  aresetn,
    input logic  s_ready,
    input logic  m_valid,
    input logic  m_ready,
    input resp_t m_data,
    input logic  cfg_valid,
    input logic  cfg_ready
);

    // Init pass blocks requests right after reset
    a_reset_blocks: assert property (@(posedge aclk)
        !aresetn |=> !s_ready)
        else $error("s_ready high right after reset");

    // Config write rebuilds the list and blocks requests
    a_cfg_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        (cfg_valid && cfg_ready) |=> !s_ready)
        else $error("s_ready high right after config write");

    // Refused allocate: no offset and nothing left
    a_empty_beat: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.status == ST_EMPTY) |->
            (m_data.block_offset == '0 && m_data.free_blocks == '0))
        else $error("empty result with offset or nonzero count");

    // Ignored free carries no offset
    a_full_beat: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.status == ST_FULL) |-> m_data.block_offset == '0)
        else $error("full result with nonzero offset");

    // Stalled result beat holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_data)))
        else $error("result beat changed while stalled");

endmodule

bind fixed_block_free_list_allocator_unit fbfl_checker u_fbfl_checker (.*);

@@ tb/sv/fixed_block_free_list_allocator_unit_test.sv @@
`timescale 1ns / 1ps

module fixed_block_free_list_allocator_unit_test;
    import fbfl_pkg::*;

    localparam int          PAGE_SZ    = PAGE_BYTES_DEF;
    localparam int          MAX_BLK    = MAX_BLOCKS_DEF;
    localparam int          CYCLE_CAP  = 300000;
    localparam int          REPORT_MAX = 10;
    localparam int          PHASES     = 8;

    logic              aclk = 1'b0;
    logic              aresetn;
    logic              s_valid;
    logic              s_ready;
    req_t              s_data;
    logic              m_valid;
    logic              m_ready;
    resp_t             m_data;
    logic              cfg_valid;
    logic              cfg_ready;
    logic [LOG2_W-1:0] cfg_data;

    fixed_block_free_list_allocator_unit #(
        .PAGE_BYTES(PAGE_SZ),
        .MAX_BLOCKS(MAX_BLK)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_data   (s_data),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data (cfg_data)
    );

    // 8 ns clock
    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // Pool shadow: block size code, link table, list head, free count
    logic [LOG2_W-1:0] pool_log2;
    logic [FB_W-1:0]   link_mem [MAX_BLK];
    logic [FB_W-1:0]   head_idx;
    int unsigned       free_cnt;

    resp_t       pending_replies [$];
    int unsigned held_offsets [$];
    int unsigned mismatch_cnt = 0;
    int unsigned cycle_cnt = 0;
    bit          s_valid_on = 1'b0;
    int unsigned burst_left = 0;

    function automatic int unsigned pool_blocks();
        int unsigned n = PAGE_SZ >> pool_log2;
        if (n > MAX_BLK) n = MAX_BLK;
        if (n == 0) n = 1;
        return n;
    endfunction

    // Register write: new block size, list rebuilt in block order
    function automatic void pool_configure(logic [LOG2_W-1:0] code);
        pool_log2 = code;
        for (int i = 0; i < MAX_BLK; i++) link_mem[i] = FB_W'(i + 1);
        head_idx = '0;
        free_cnt = pool_blocks();
    endfunction

    // Expected reply for one request; updates the shadow pool
    function automatic resp_t serve_request(req_t r);
        resp_t       res;
        int unsigned n;
        int unsigned idx;
        int unsigned h;
        n = pool_blocks();
        res.status       = ST_OK;
        res.block_offset = '0;
        if (r.req_type == REQ_ALLOC) begin
            if (free_cnt == 0) begin
                res.status = ST_EMPTY;
            end else begin
                h = head_idx;
                res.block_offset = OFF_W'((h << pool_log2) & 'hFFF);
                if (h < MAX_BLK) head_idx = link_mem[h];
                free_cnt--;
            end
        end else begin
            if (free_cnt >= n) begin
                res.status = ST_FULL;
            end else begin
                idx = r.free_offset >> pool_log2;
                if (idx >= n) idx = n - 1;
                link_mem[idx] = head_idx;
                head_idx = FB_W'(idx);
                free_cnt++;
            end
        end
        res.free_blocks = FB_W'(free_cnt);
        return res;
    endfunction

    // Directed stimulus rows
    typedef struct {
        bit                is_cfg;
        logic [LOG2_W-1:0] cfg_val;
        req_t              req;
        bit                known;
        resp_t             want;
    } dir_row_t;

    dir_row_t dir_rows [$];

    function automatic dir_row_t row_cfg(logic [LOG2_W-1:0] v);
        dir_row_t row;
        row = '{default: '0};
        row.is_cfg  = 1'b1;
        row.cfg_val = v;
        return row;
    endfunction

    function automatic dir_row_t row_req(logic t, logic [OFF_W-1:0] off);
        dir_row_t row;
        row = '{default: '0};
        row.req.req_type    = t;
        row.req.free_offset = off;
        return row;
    endfunction

    function automatic dir_row_t row_chk(logic t, logic [OFF_W-1:0] off, status_t st,
                                         logic [OFF_W-1:0] boff, logic [FB_W-1:0] fb);
        dir_row_t row;
        row = row_req(t, off);
        row.known             = 1'b1;
        row.want.status       = st;
        row.want.block_offset = boff;
        row.want.free_blocks  = fb;
        return row;
    endfunction

    // Drop s_valid once per step at most
    task automatic drop_valid();
        if (s_valid_on) begin
            s_valid <= 1'b0;
            s_valid_on = 1'b0;
        end
    endtask

    task automatic hold_off(int unsigned n);
        if (n > 0) begin
            drop_valid();
            repeat (n) @(posedge aclk);
        end
    endtask

    // Sender bursts with random gaps
    task automatic pace();
        if (burst_left == 0) begin
            if ($urandom_range(0, 3) == 0) hold_off(0);
            else hold_off($urandom_range(1, 6));
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40)
                                                     : $urandom_range(1, 10);
        end
        burst_left--;
    endtask

    // One request beat; the expectation is queued at acceptance
    task automatic push_req(input req_t r, input bit known, input resp_t known_resp,
                            output resp_t got);
        resp_t p;
        s_data  <= r;
        s_valid <= 1'b1;
        s_valid_on = 1'b1;
        do @(posedge aclk); while (!s_ready);
        p = serve_request(r);
        pending_replies.push_back(known ? known_resp : p);
        got = p;
    endtask

    // Pause the sender until every reply is back
    task automatic drain();
        drop_valid();
        while (pending_replies.size() != 0) @(posedge aclk);
    endtask

    task automatic write_cfg(input logic [LOG2_W-1:0] v);
        drain();
        cfg_data  <= v;
        cfg_valid <= 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        pool_configure(v);
        held_offsets.delete();
    endtask

    // Receiver stall pattern: m_ready follows one of four randomly chosen modes
    int unsigned rdy_mode = 0;
    int unsigned rdy_left = 0;

    always @(posedge aclk) begin
        if (rdy_left == 0) begin
            rdy_mode = $urandom_range(0, 3);
            rdy_left = $urandom_range(20, 120);
        end else begin
            rdy_left--;
        end
        case (rdy_mode)
            0: m_ready <= 1'b1;
            1: m_ready <= 1'($urandom_range(0, 1));
            2: m_ready <= ($urandom_range(0, 3) == 0);
            default: m_ready <= (rdy_left % 3) != 0;
        endcase
    end

    // Reply checker
    resp_t want_resp;

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (pending_replies.size() == 0) begin
                if (mismatch_cnt < REPORT_MAX)
                    $display("unexpected reply: status %0d offset 0x%03h free %0d",
                             m_data.status, m_data.block_offset, m_data.free_blocks);
                mismatch_cnt++;
            end else begin
                want_resp = pending_replies.pop_front();
                if (m_data.status !== want_resp.status
                    || m_data.block_offset !== want_resp.block_offset
                    || m_data.free_blocks !== want_resp.free_blocks) begin
                    if (mismatch_cnt < REPORT_MAX)
                        $display({"reply mismatch: exp status %0d offset 0x%03h free %0d,",
                                  " got status %0d offset 0x%03h free %0d"},
                                 want_resp.status, want_resp.block_offset,
                                 want_resp.free_blocks, m_data.status,
                                 m_data.block_offset, m_data.free_blocks);
                    mismatch_cnt++;
                end
            end
        end
    end

    // Watchdog
    always @(posedge aclk) begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_CAP) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Stimulus
    initial begin
        resp_t       got;
        req_t        r;
        int unsigned n_items;
        int unsigned pct_alloc;
        int unsigned k;
        int unsigned blk;

        aresetn   <= 1'b0;
        s_valid   <= 1'b0;
        s_data    <= '0;
        m_ready   <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_data  <= '0;
        pool_configure(BLK_LOG2_RST);

        // Directed table; reset code gives 32-byte blocks, 128 of them
        dir_rows.push_back(row_chk(REQ_FREE,  12'h000, ST_FULL,  12'h000, 10'd128));
        dir_rows.push_back(row_chk(REQ_ALLOC, 12'h000, ST_OK,    12'h000, 10'd127));
        dir_rows.push_back(row_chk(REQ_ALLOC, 12'hFFF, ST_OK,    12'h020, 10'd126));
        // misaligned free hits block 1
        dir_rows.push_back(row_chk(REQ_FREE,  12'h021, ST_OK,    12'h000, 10'd127));
        dir_rows.push_back(row_chk(REQ_ALLOC, 12'h000, ST_OK,    12'h020, 10'd126));
        dir_rows.push_back(row_req(REQ_FREE,  12'hFFF));
        // double free of a block already on the list
        dir_rows.push_back(row_req(REQ_FREE,  12'hFFF));
        // one 4 KiB block: empty and full pool
        dir_rows.push_back(row_cfg(4'd12));
        dir_rows.push_back(row_chk(REQ_ALLOC, 12'h000, ST_OK,    12'h000, 10'd0));
        dir_rows.push_back(row_chk(REQ_ALLOC, 12'hFFF, ST_EMPTY, 12'h000, 10'd0));
        dir_rows.push_back(row_chk(REQ_FREE,  12'hFFF, ST_OK,    12'h000, 10'd1));
        dir_rows.push_back(row_chk(REQ_FREE,  12'h000, ST_FULL,  12'h000, 10'd1));
        // 8-byte blocks: 512 of them, the most the pool holds
        dir_rows.push_back(row_cfg(4'd3));
        dir_rows.push_back(row_chk(REQ_ALLOC, 12'h000, ST_OK,    12'h000, 10'd511));
        dir_rows.push_back(row_chk(REQ_FREE,  12'hFFF, ST_OK,    12'h000, 10'd512));
        dir_rows.push_back(row_chk(REQ_ALLOC, 12'h000, ST_OK,    12'hFF8, 10'd511));
        dir_rows.push_back(row_req(REQ_ALLOC, 12'h000));
        // code 0: capped at 512 blocks, frees past the end saturate
        dir_rows.push_back(row_cfg(4'd0));
        dir_rows.push_back(row_chk(REQ_ALLOC, 12'h000, ST_OK,    12'h000, 10'd511));
        dir_rows.push_back(row_chk(REQ_FREE,  12'hFFF, ST_OK,    12'h000, 10'd512));
        dir_rows.push_back(row_chk(REQ_ALLOC, 12'h000, ST_OK,    12'h1FF, 10'd511));
        dir_rows.push_back(row_req(REQ_FREE,  12'h7FF));
        // code 15: shift leaves no block, pool of one
        dir_rows.push_back(row_cfg(4'd15));
        dir_rows.push_back(row_chk(REQ_ALLOC, 12'h000, ST_OK,    12'h000, 10'd0));
        dir_rows.push_back(row_chk(REQ_FREE,  12'h123, ST_OK,    12'h000, 10'd1));

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (dir_rows[i]) begin
            if (dir_rows[i].is_cfg) begin
                write_cfg(dir_rows[i].cfg_val);
            end else begin
                pace();
                push_req(dir_rows[i].req, dir_rows[i].known, dir_rows[i].want, got);
            end
        end

        // Random phases, mostly small pools so empty and full both happen
        for (int ph = 0; ph < PHASES; ph++) begin
            if ($urandom_range(0, 3) == 0) write_cfg(LOG2_W'($urandom_range(0, 15)));
            else write_cfg(LOG2_W'($urandom_range(7, 12)));
            n_items   = $urandom_range(50, 75);
            pct_alloc = $urandom_range(30, 70);
            for (int i = 0; i < n_items; i++) begin
                if (ph == 2 && i == n_items / 2) drain();
                r.free_offset = OFF_W'($urandom);
                if ($urandom_range(0, 99) < pct_alloc) begin
                    r.req_type = REQ_ALLOC;
                end else begin
                    r.req_type = REQ_FREE;
                    // mostly blocks we hold, sometimes misaligned; rest is noise
                    if (held_offsets.size() != 0 && $urandom_range(0, 99) < 85) begin
                        k   = $urandom_range(0, held_offsets.size() - 1);
                        blk = 1 << pool_log2;
                        r.free_offset = OFF_W'(held_offsets[k]);
                        if ($urandom_range(0, 3) == 0)
                            r.free_offset = OFF_W'((held_offsets[k] | ($urandom & (blk - 1)))
                                                   & 'hFFF);
                        held_offsets.delete(k);
                    end
                end
                pace();
                push_req(r, 1'b0, '0, got);
                if (r.req_type == REQ_ALLOC && got.status == ST_OK)
                    held_offsets.push_back(got.block_offset);
            end
        end

        drain();
        repeat (8) @(posedge aclk);
        if (mismatch_cnt == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
